@@ rtl/core/mscc_pkg.sv @@
// Package: types, edge codes and case tables for the marching-squares cell contour block.
package mscc_pkg;

    localparam int ZW   = 32;
    localparam int DENW = 34;
    localparam int REMW = 35;
    localparam int FW   = 16;

    localparam logic [1:0] EDGE_BOTTOM = 2'd0;
    localparam logic [1:0] EDGE_RIGHT  = 2'd1;
    localparam logic [1:0] EDGE_TOP    = 2'd2;
    localparam logic [1:0] EDGE_LEFT   = 2'd3;

    localparam logic REG_LEVEL = 1'b0;

    localparam logic [FW-1:0] FRAC_HALF = 16'd32768;
    localparam logic [FW-1:0] FRAC_ZERO = 16'd0;
    localparam logic [FW-1:0] FRAC_MAX  = 16'd65535;

    localparam logic [3:0] CASE_EMPTY  = 4'd0;
    localparam logic [3:0] CASE_FULL   = 4'd15;
    localparam logic [3:0] CASE_SADDLE_A = 4'd5;
    localparam logic [3:0] CASE_SADDLE_B = 4'd10;

    typedef struct packed {
        logic [9:0]           cell_col;
        logic [9:0]           cell_row;
        logic signed [ZW-1:0] z_bottom_left;
        logic signed [ZW-1:0] z_bottom_right;
        logic signed [ZW-1:0] z_top_right;
        logic signed [ZW-1:0] z_top_left;
    } t_cell_in;

    typedef struct packed {
        logic [9:0]    out_col;
        logic [9:0]    out_row;
        logic [1:0]    start_edge;
        logic [FW-1:0] start_frac;
        logic [1:0]    end_edge;
        logic [FW-1:0] end_frac;
        logic          last_segment;
    } t_seg_out;

    // one edge's division in flight
    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [DENW-1:0] den;
        logic [FW-1:0]   q;
        logic            done;
    } t_div;

    // per-cell sideband that travels alongside the dividers
    typedef struct packed {
        logic [9:0] col;
        logic [9:0] row;
        logic [1:0] nseg;
        logic [1:0] e0s;
        logic [1:0] e0e;
        logic [1:0] e1s;
        logic [1:0] e1e;
    } t_side;

    function automatic logic [1:0] seg_start(input logic [3:0] c);
        logic [1:0] e;
        case (c) inside
            4'd1, 4'd3, 4'd7, 4'd14: e = EDGE_LEFT;
            4'd4, 4'd11, 4'd12:      e = EDGE_RIGHT;
            4'd8:                    e = EDGE_TOP;
            default:                 e = EDGE_BOTTOM;
        endcase
        return e;
    endfunction

    function automatic logic [1:0] seg_end(input logic [3:0] c);
        logic [1:0] e;
        case (c) inside
            4'd2, 4'd13:              e = EDGE_RIGHT;
            4'd3:                     e = EDGE_RIGHT;
            4'd4, 4'd6, 4'd7, 4'd9, 4'd11: e = EDGE_TOP;
            4'd8, 4'd12:              e = EDGE_LEFT;
            default:                  e = EDGE_BOTTOM;
        endcase
        return e;
    endfunction

endpackage

@@ rtl/core/mscc_div_stage.sv @@
// Two restoring-division steps for one edge fraction, registered.
module mscc_div_stage
    import mscc_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    t_div n_d;
    t_div r_d;

    always_comb begin
        logic [REMW-1:0] r2;
        n_d = i_d;
        for (int k = 0; k < 2; k++) begin
            r2 = {n_d.rem[REMW-2:0], 1'b0};
            if (!n_d.done) begin
                if (r2 >= {1'b0, n_d.den}) begin
                    n_d.rem = r2 - {1'b0, n_d.den};
                    n_d.q   = {n_d.q[FW-2:0], 1'b1};
                end else begin
                    n_d.rem = r2;
                    n_d.q   = {n_d.q[FW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

@@ rtl/core/mscc_out_buf.sv @@
// Output buffer: holds one cell's segments and hands them out one beat at a time.
module mscc_out_buf
    import mscc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_seg_out i_seg0,
    input  t_seg_out i_seg1,
    input  logic     i_two,
    input  logic     i_stall,
    output logic     o_valid,
    output t_seg_out o_seg,
    output logic     o_free
);

    logic     r_have, r_pend;
    logic     n_have, n_pend;
    t_seg_out r_cur, r_nxt;
    logic     take;

    assign take   = r_have && !i_stall;
    assign o_free = !r_have || (take && !r_pend);

    always_comb begin
        n_have = r_have;
        n_pend = r_pend;
        if (take) begin
            n_have = r_pend;
            n_pend = 1'b0;
        end
        if (i_load) begin
            n_have = 1'b1;
            n_pend = i_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_have <= n_have;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cur <= i_seg0;
            r_nxt <= i_seg1;
        end else if (take && r_pend) begin
            r_cur <= r_nxt;
        end
    end

    assign o_valid = r_have;
    assign o_seg   = r_cur;

endmodule

@@ rtl/core/marching_squares_cell_contour.sv @@
// Top level: marching-squares contour of one grid cell, eleven-stage pipeline.
// Throughput: one cell per cycle unless the receiver stalls; a saddle cell holds
// the pipe while its second segment beat leaves. Fractions come from four 16-bit
// restoring dividers, two quotient bits per stage, eight stages.
// Reset (synchronous, active low) clears valid bits, the output buffer and level.
module marching_squares_cell_contour
    import mscc_pkg::*;
#(
    parameter int GRID_SIDE = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cell beats
    input  logic        i_valid,
    output logic        o_stall,
    input  t_cell_in    i_cell,
    // segment beats
    output logic        o_valid,
    input  logic        i_stall,
    output t_seg_out    o_seg,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NDIV = 8;
    localparam logic [16:0] LIM = 17'(GRID_SIDE - 1);

    // ---------------- register port ----------------
    logic signed [ZW-1:0] r_level;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LEVEL) ? r_level : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_LEVEL) begin
            r_level <= pwdata;
        end
    end

    // ---------------- global advance ----------------
    // Every stage moves together when the output buffer can take the tail.
    logic adv;
    logic buf_free;

    assign adv     = buf_free;
    assign o_stall = !adv;

    // ---------------- stage A: capture ----------------
    logic     r_va;
    t_cell_in r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (adv) begin
            r_va <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a <= i_cell;
        end
    end

    // ---------------- stage B: differences, case code ----------------
    // edge order: bottom, right, top, left; z0 is the lower or left node
    logic signed [ZW-1:0]  z0 [4];
    logic signed [ZW-1:0]  z1 [4];
    logic signed [ZW:0]    n_num [4];
    logic signed [ZW:0]    n_den [4];
    logic signed [ZW:0]    r_num [4];
    logic signed [ZW:0]    r_den [4];
    logic [3:0]            n_code;
    logic                  n_skip;
    logic signed [ZW:0]    r_s01, r_s23;
    logic [3:0]            r_code;
    logic                  r_skip;
    logic [9:0]            r_bcol, r_brow;
    logic                  r_vb;

    always_comb begin
        z0[0] = r_a.z_bottom_left;  z1[0] = r_a.z_bottom_right;
        z0[1] = r_a.z_bottom_right; z1[1] = r_a.z_top_right;
        z0[2] = r_a.z_top_left;     z1[2] = r_a.z_top_right;
        z0[3] = r_a.z_bottom_left;  z1[3] = r_a.z_top_left;
        for (int e = 0; e < 4; e++) begin
            n_num[e] = {r_level[ZW-1], r_level} - {z0[e][ZW-1], z0[e]};
            n_den[e] = {z1[e][ZW-1], z1[e]} - {z0[e][ZW-1], z0[e]};
        end
        n_code = {r_a.z_top_left <= r_level, r_a.z_top_right <= r_level,
                  r_a.z_bottom_right <= r_level, r_a.z_bottom_left <= r_level};
        n_skip = ({7'd0, r_a.cell_col} >= LIM) || ({7'd0, r_a.cell_row} >= LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (adv) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int e = 0; e < 4; e++) begin
                r_num[e] <= n_num[e];
                r_den[e] <= n_den[e];
            end
            r_s01  <= {r_a.z_bottom_left[ZW-1], r_a.z_bottom_left}
                    + {r_a.z_bottom_right[ZW-1], r_a.z_bottom_right};
            r_s23  <= {r_a.z_top_right[ZW-1], r_a.z_top_right}
                    + {r_a.z_top_left[ZW-1], r_a.z_top_left};
            r_code <= n_code;
            r_skip <= n_skip;
            r_bcol <= r_a.cell_col;
            r_brow <= r_a.cell_row;
        end
    end

    // ---------------- stage C: normalise, special cases, saddle ----------------
    t_div  n_div [4];
    t_side n_side;
    logic  cin;

    always_comb begin
        logic signed [DENW-1:0] nm, dn;
        for (int e = 0; e < 4; e++) begin
            nm = {r_num[e][ZW], r_num[e]};
            dn = {r_den[e][ZW], r_den[e]};
            if (dn < 0) begin
                nm = -nm;
                dn = -dn;
            end
            n_div[e].rem  = {1'b0, nm};
            n_div[e].den  = dn;
            n_div[e].q    = FRAC_ZERO;
            n_div[e].done = 1'b1;
            if (dn == 0) begin
                n_div[e].q = FRAC_HALF;
            end else if (nm <= 0) begin
                n_div[e].q = FRAC_ZERO;
            end else if (nm >= dn) begin
                n_div[e].q = FRAC_MAX;
            end else begin
                n_div[e].done = 1'b0;
            end
        end

        // exact average test: sum of the four heights against four times level, signed
        cin = $signed({r_s01[ZW], r_s01} + {r_s23[ZW], r_s23})
              <= $signed({{2{r_level[ZW-1]}}, r_level} <<< 2);

        n_side.col  = r_bcol;
        n_side.row  = r_brow;
        n_side.e0s  = seg_start(r_code);
        n_side.e0e  = seg_end(r_code);
        n_side.e1s  = EDGE_BOTTOM;
        n_side.e1e  = EDGE_BOTTOM;
        n_side.nseg = 2'd1;
        if (r_skip || r_code == CASE_EMPTY || r_code == CASE_FULL) begin
            n_side.nseg = 2'd0;
        end else if (r_code == CASE_SADDLE_A || r_code == CASE_SADDLE_B) begin
            n_side.nseg = 2'd2;
            n_side.e0s  = EDGE_LEFT;
            if ((r_code == CASE_SADDLE_A) == cin) begin
                n_side.e0e = EDGE_TOP;
                n_side.e1s = EDGE_BOTTOM;
                n_side.e1e = EDGE_RIGHT;
            end else begin
                n_side.e0e = EDGE_BOTTOM;
                n_side.e1s = EDGE_RIGHT;
                n_side.e1e = EDGE_TOP;
            end
        end
    end

    logic  r_vc;
    t_div  r_c [4];
    t_side r_cside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (adv) begin
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c     <= n_div;
            r_cside <= n_side;
        end
    end

    // ---------------- stages D1..D8: dividers ----------------
    t_div         dpipe [NDIV+1][4];
    logic [NDIV-1:0] r_vd;
    t_side        r_dside [NDIV];

    for (genvar e = 0; e < 4; e++) begin : g_in
        assign dpipe[0][e] = r_c[e];
    end

    for (genvar s = 0; s < NDIV; s++) begin : g_st
        for (genvar e = 0; e < 4; e++) begin : g_edge
            mscc_div_stage u_div (
                .i_clk (i_clk),
                .i_en  (adv),
                .i_d   (dpipe[s][e]),
                .o_d   (dpipe[s+1][e])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (adv) begin
            r_vd <= {r_vd[NDIV-2:0], r_vc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dside[0] <= r_cside;
            for (int s = 1; s < NDIV; s++) begin
                r_dside[s] <= r_dside[s-1];
            end
        end
    end

    // ---------------- assemble segments ----------------
    t_side    tail;
    t_seg_out seg0, seg1;
    logic     load;

    function automatic logic [FW-1:0] pick(input logic [1:0] e, input t_div d [4]);
        return d[e].q;
    endfunction

    always_comb begin
        tail = r_dside[NDIV-1];
        seg0.out_col      = tail.col;
        seg0.out_row      = tail.row;
        seg0.start_edge   = tail.e0s;
        seg0.start_frac   = pick(tail.e0s, dpipe[NDIV]);
        seg0.end_edge     = tail.e0e;
        seg0.end_frac     = pick(tail.e0e, dpipe[NDIV]);
        seg0.last_segment = (tail.nseg == 2'd1);
        seg1.out_col      = tail.col;
        seg1.out_row      = tail.row;
        seg1.start_edge   = tail.e1s;
        seg1.start_frac   = pick(tail.e1s, dpipe[NDIV]);
        seg1.end_edge     = tail.e1e;
        seg1.end_frac     = pick(tail.e1e, dpipe[NDIV]);
        seg1.last_segment = 1'b1;
    end

    assign load = adv && r_vd[NDIV-1] && (tail.nseg != 2'd0);

    mscc_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_seg0  (seg0),
        .i_seg1  (seg1),
        .i_two   (tail.nseg == 2'd2),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_seg   (o_seg),
        .o_free  (buf_free)
    );

endmodule

@@ dv/marching_squares_cell_contour_tb.sv @@
// Testbench for the marching-squares cell contour block: directed and random cells.
`timescale 1ns / 100ps

module marching_squares_cell_contour_tb;
    import mscc_pkg::*;

    localparam int GRID    = 1024;
    localparam int WDOG    = 4000;
    localparam int LATENCY = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    t_cell_in    i_cell;
    logic        o_valid;
    logic        i_stall;
    t_seg_out    o_seg;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    marching_squares_cell_contour dut (.*);

    // model copy of the level register
    logic signed [31:0] cur_level;
    t_seg_out           seg_q[$];
    int                 n_fail;
    int                 idle_cycles;
    int                 snd_idle_pct;
    int                 rcv_idle_pct;
    int                 hold_off;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Crossing fraction from node z0 to node z1, exact in 64 bits.
    function automatic logic [15:0] cross_frac(input logic signed [31:0] z0,
                                               input logic signed [31:0] z1);
        longint num;
        longint den;
        num = longint'(cur_level) - longint'(z0);
        den = longint'(z1) - longint'(z0);
        if (den == 0) return FRAC_HALF;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) return FRAC_ZERO;
        if (num >= den) return FRAC_MAX;
        return 16'((num <<< 16) / den);
    endfunction

    function automatic logic [15:0] edge_crossing(input logic [1:0] e, input t_cell_in c);
        case (e)
            EDGE_BOTTOM: return cross_frac(c.z_bottom_left, c.z_bottom_right);
            EDGE_RIGHT:  return cross_frac(c.z_bottom_right, c.z_top_right);
            EDGE_TOP:    return cross_frac(c.z_top_left, c.z_top_right);
            default:     return cross_frac(c.z_bottom_left, c.z_top_left);
        endcase
    endfunction

    function automatic t_seg_out make_seg(input t_cell_in c, input logic [1:0] a,
                                          input logic [1:0] b, input logic fin);
        t_seg_out s;
        s.out_col      = c.cell_col;
        s.out_row      = c.cell_row;
        s.start_edge   = a;
        s.start_frac   = edge_crossing(a, c);
        s.end_edge     = b;
        s.end_frac     = edge_crossing(b, c);
        s.last_segment = fin;
        return s;
    endfunction

    // Append one expected segment at the back of the queue.
    task automatic expect_seg(input t_seg_out s);
        seg_q = {seg_q, s};
    endtask

    // Queue the segments a cell should produce.
    task automatic predict_segments(input t_cell_in c);
        logic [3:0] code;
        logic [1:0] a;
        logic [1:0] b;
        logic       centre_in;
        longint     total;
        code = {c.z_top_left <= cur_level, c.z_top_right <= cur_level,
                c.z_bottom_right <= cur_level, c.z_bottom_left <= cur_level};
        if (c.cell_col >= GRID - 1 || c.cell_row >= GRID - 1) return;
        if (code == CASE_EMPTY || code == CASE_FULL) return;
        if (code == CASE_SADDLE_A || code == CASE_SADDLE_B) begin
            total = longint'(c.z_bottom_left) + longint'(c.z_bottom_right)
                  + longint'(c.z_top_right) + longint'(c.z_top_left);
            centre_in = total <= 4 * longint'(cur_level);
            if ((code == CASE_SADDLE_A) == centre_in) begin
                expect_seg(make_seg(c, EDGE_LEFT, EDGE_TOP, 1'b0));
                expect_seg(make_seg(c, EDGE_BOTTOM, EDGE_RIGHT, 1'b1));
            end else begin
                expect_seg(make_seg(c, EDGE_LEFT, EDGE_BOTTOM, 1'b0));
                expect_seg(make_seg(c, EDGE_RIGHT, EDGE_TOP, 1'b1));
            end
            return;
        end
        // single-segment edges, per case
        case (code)
            4'd1:    begin a = EDGE_LEFT;   b = EDGE_BOTTOM; end
            4'd2:    begin a = EDGE_BOTTOM; b = EDGE_RIGHT;  end
            4'd3:    begin a = EDGE_LEFT;   b = EDGE_RIGHT;  end
            4'd4:    begin a = EDGE_RIGHT;  b = EDGE_TOP;    end
            4'd6:    begin a = EDGE_BOTTOM; b = EDGE_TOP;    end
            4'd7:    begin a = EDGE_LEFT;   b = EDGE_TOP;    end
            4'd8:    begin a = EDGE_TOP;    b = EDGE_LEFT;   end
            4'd9:    begin a = EDGE_BOTTOM; b = EDGE_TOP;    end
            4'd11:   begin a = EDGE_RIGHT;  b = EDGE_TOP;    end
            4'd12:   begin a = EDGE_RIGHT;  b = EDGE_LEFT;   end
            4'd13:   begin a = EDGE_BOTTOM; b = EDGE_RIGHT;  end
            default: begin a = EDGE_LEFT;   b = EDGE_BOTTOM; end
        endcase
        expect_seg(make_seg(c, a, b, 1'b1));
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        n_fail++;
    endtask

    // Segment checker: compares each accepted beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_seg_out w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (seg_q.size() == 0) begin
                report_mismatch("unexpected segment, col", o_seg.out_col, -1);
            end else begin
                w = seg_q.pop_front();
                if (o_seg.out_col !== w.out_col)
                    report_mismatch("out_col", o_seg.out_col, w.out_col);
                if (o_seg.out_row !== w.out_row)
                    report_mismatch("out_row", o_seg.out_row, w.out_row);
                if (o_seg.start_edge !== w.start_edge)
                    report_mismatch("start_edge", o_seg.start_edge, w.start_edge);
                if (o_seg.start_frac !== w.start_frac)
                    report_mismatch("start_frac", o_seg.start_frac, w.start_frac);
                if (o_seg.end_edge !== w.end_edge)
                    report_mismatch("end_edge", o_seg.end_edge, w.end_edge);
                if (o_seg.end_frac !== w.end_frac)
                    report_mismatch("end_frac", o_seg.end_frac, w.end_frac);
                if (o_seg.last_segment !== w.last_segment)
                    report_mismatch("last_segment", o_seg.last_segment, w.last_segment);
            end
        end
    end

    // Receiver stall: random, or a long hold-off while hold_off counts down.
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    // Watchdog: cycles without any beat accepted on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG) begin
            $display("watchdog expired");
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Send one cell beat, with random idle gaps ahead of it.
    task automatic send_cell(input t_cell_in c);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell  <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_segments(c);
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every expectation has drained, then the pipe's length.
    task automatic drain();
        end_burst();
        while (seg_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LEVEL, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_level = v;
        @(posedge i_clk);
    endtask

    function automatic t_cell_in cell_of(input int col, input int row, input int bl,
                                         input int br, input int tr, input int tl);
        t_cell_in c;
        c.cell_col       = 10'(col);
        c.cell_row       = 10'(row);
        c.z_bottom_left  = bl;
        c.z_bottom_right = br;
        c.z_top_right    = tr;
        c.z_top_left     = tl;
        return c;
    endfunction

    // Heights clustered near the level so every case and fraction turns up.
    function automatic logic [31:0] near_level(input int spread);
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return cur_level;
            default: return cur_level + $signed($urandom_range(2 * spread)) - spread;
        endcase
    endfunction

    function automatic t_cell_in random_cell();
        t_cell_in c;
        int sp;
        sp = 1 << $urandom_range(2, 20);
        c.cell_col = ($urandom_range(19) == 0) ? 10'($urandom_range(1021, 1023))
                                               : 10'($urandom());
        c.cell_row = ($urandom_range(19) == 0) ? 10'($urandom_range(1021, 1023))
                                               : 10'($urandom());
        c.z_bottom_left  = near_level(sp);
        c.z_bottom_right = near_level(sp);
        c.z_top_right    = near_level(sp);
        c.z_top_left     = near_level(sp);
        return c;
    endfunction

    // Every case code at level zero, equal heights, edge of grid, extremes.
    task automatic test_directed();
        for (int k = 0; k < 16; k++)
            send_cell(cell_of(k, k + 1, k[0] ? -1024 : 2048, k[1] ? -300 : 700,
                              k[2] ? 0 : 1, k[3] ? -5000 : 9));
        // saddles either way round
        send_cell(cell_of(3, 4, -100, 10, -100, 10));
        send_cell(cell_of(3, 5, -10, 100, -10, 100));
        // equal heights along an edge within one crossing
        send_cell(cell_of(1, 1, 5, 5, -5, -5));
        // cells near and past the grid edge
        send_cell(cell_of(1022, 7, -1, 1, 1, 1));
        send_cell(cell_of(7, 1023, -1, 1, 1, 1));
        send_cell(cell_of(1021, 1021, -1, 1, 1, 1));
        // height extremes
        send_cell(cell_of(0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_cell(cell_of(1023, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff));
        drain();
    endtask

    task automatic test_random(input int n, input int s_pct, input int r_pct);
        snd_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        for (int k = 0; k < n; k++) send_cell(random_cell());
        drain();
    endtask

    // Receiver holds off for a long stretch while cells keep coming.
    task automatic test_backpressure();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_off     = 150;
        for (int k = 0; k < 60; k++) send_cell(random_cell());
        drain();
    endtask

    task automatic test_levels();
        write_level(32'h7fff_ffff);
        test_random(40, 10, 10);
        write_level(32'h8000_0000);
        test_random(40, 10, 10);
        write_level(32'hffff_fc00);
        test_random(60, 0, 0);
        write_level(32'd5120);
        test_random(60, 30, 30);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cell       = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_stall      = 1'b0;
        n_fail       = 0;
        idle_cycles  = 0;
        hold_off     = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        cur_level    = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(150, 17, 80);
        test_random(150, 80, 17);
        test_random(120, 0, 0);
        test_backpressure();
        test_levels();

        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
